FILE: hw/rtl/bvns_pkg.sv
// shared constants for the bicubic value noise sampler
`default_nettype none
package bvns_pkg;
  localparam logic [63:0] MixMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMul2 = 64'h94d049bb133111eb;
  localparam logic [1:0] RegSeed = 2'd0;
  localparam logic [1:0] RegCell = 2'd1;
  localparam logic [1:0] RegAmp  = 2'd2;
  localparam int CfgIdxW = 2;
  localparam logic [30:0] CellReset = 31'd1024;
  localparam logic [30:0] AmpReset  = 31'd65536;
endpackage
`default_nettype wire

FILE: hw/rtl/bvns_hash.sv
// pipelined splitmix64 finalizer, low 32 bits out as a signed corner value
`default_nettype none
module bvns_hash import bvns_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] key,
  output logic signed [31:0] value
);
  logic [63:0] x1, x2, k1, k2s;
  logic [63:0] pa_lo, pb_lo;
  logic [31:0] pa_m1, pa_m2, pb_m1, pb_m2;
  logic [31:0] hv;
  assign x1 = key ^ (key >> 30);
  // stage 1: 32-bit partial products of the first multiply
  always_ff @(posedge clk) if (en) begin
    pa_lo <= 64'(x1[31:0]) * 64'(MixMul1[31:0]);
    pa_m1 <= x1[31:0] * MixMul1[63:32];
    pa_m2 <= x1[63:32] * MixMul1[31:0];
  end
  // stage 2: low 64 bits of the first product
  always_ff @(posedge clk) if (en) k1 <= pa_lo + {pa_m1 + pa_m2, 32'd0};
  assign x2 = k1 ^ (k1 >> 27);
  // stage 3: 32-bit partial products of the second multiply
  always_ff @(posedge clk) if (en) begin
    pb_lo <= 64'(x2[31:0]) * 64'(MixMul2[31:0]);
    pb_m1 <= x2[31:0] * MixMul2[63:32];
    pb_m2 <= x2[63:32] * MixMul2[31:0];
  end
  assign k2s = pb_lo + {pb_m1 + pb_m2, 32'd0};
  // stage 4: second product sum and final fold
  always_ff @(posedge clk) if (en) hv <= 32'(k2s ^ (k2s >> 31));
  assign value = $signed(hv);
endmodule
`default_nettype wire

FILE: hw/rtl/bvns_catmull.sv
// pipelined catmull-rom pass on four signed points, fraction of 16 bits
`default_nettype none
module bvns_catmull #(
  parameter int W = 36
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [W-1:0] p0,
  input  wire logic signed [W-1:0] p1,
  input  wire logic signed [W-1:0] p2,
  input  wire logic signed [W-1:0] p3,
  input  wire logic        [15:0] t,
  output logic signed [W+3:0]      r
);
  localparam int CW = W + 4;
  logic signed [CW-1:0] a, b, c, q1, s1, s2, c2, q2, pp1, pp2;
  logic [15:0] t1, t2;
  logic signed [CW+16:0] m1, m2, m3;
  // stage 1: coefficients
  always_ff @(posedge clk) if (en) begin
    a  <= 3 * (CW'(p1) - CW'(p2)) + CW'(p3) - CW'(p0);
    b  <= 2 * CW'(p0) - 5 * CW'(p1) + 4 * CW'(p2) - CW'(p3);
    c  <= CW'(p2) - CW'(p0);
    q1 <= CW'(p1);
    t1 <= t;
  end
  assign m1 = ((CW+17)'(b) <<< 16) + $signed({1'b0, t1}) * a;
  // stage 2: first horner step
  always_ff @(posedge clk) if (en) begin
    s1 <= CW'(m1 >>> 16); c2 <= c; pp1 <= q1; t2 <= t1;
  end
  assign m2 = ((CW+17)'(c2) <<< 16) + $signed({1'b0, t2}) * s1;
  logic [15:0] t3;
  // stage 3: second horner step
  always_ff @(posedge clk) if (en) begin
    s2 <= CW'(m2 >>> 16); pp2 <= pp1; t3 <= t2;
  end
  assign m3 = $signed({1'b0, t3}) * s2;
  assign q2 = CW'(m3 >>> 17);
  // stage 4: final add
  always_ff @(posedge clk) if (en) r <= pp2 + q2;
endmodule
`default_nettype wire

FILE: hw/rtl/bicubic_value_noise_sample_top.sv
// top level of the bicubic value noise sampler
//  channel | dir | handshake            | payload
//  s_axis  | in  | tvalid/tready        | tdata anchor_x, anchor_y, frac_x, frac_y
//  m_axis  | out | tvalid/tready        | tdata height, saturated
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
// one sample per cycle sustained while the output is not stalled; the pipe runs through lattice adds,
// four hash stages, two four-stage interpolation passes and three scale stages.
// reset clears the valid bits and loads register defaults.
// the whole pipe advances when the output word is free or taken; stalls hold all.
`default_nettype none
module bicubic_value_noise_sample_top import bvns_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // anchor_x, anchor_y, frac_x, frac_y
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [47:0]       m_axis_tdata,  // height[39:0], saturated, zero pad
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [63:0]  cfg_data
);
  localparam int Lat = 16;
  logic [63:0] noise_seed;
  logic [30:0] cell_width, amplitude;
  logic en;
  logic [Lat-1:0] vld;

  assign cfg_ready = 1'b1;
  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed <= '0; cell_width <= CellReset; amplitude <= AmpReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegSeed) noise_seed <= cfg_data;
      if (cfg_index == RegCell) cell_width <= cfg_data[30:0];
      if (cfg_index == RegAmp)  amplitude  <= cfg_data[30:0];
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], s_axis_tvalid};
  end
  assign m_axis_tvalid = vld[Lat-1];

  // stage 1: lattice coordinates
  logic [31:0] xs [4];
  logic [31:0] ys [4];
  logic [15:0] ftx [9];
  logic [15:0] fty [5];
  always_ff @(posedge clk) if (en) begin
    for (int i = 0; i < 4; i++) begin
      xs[i] <= s_axis_tdata[31:0]  + 32'((i - 1) * {1'b0, cell_width});
      ys[i] <= s_axis_tdata[63:32] + 32'((i - 1) * {1'b0, cell_width});
    end
    ftx[0] <= s_axis_tdata[79:64];
    fty[0] <= s_axis_tdata[95:80];
  end
  // fraction delay lines
  always_ff @(posedge clk) if (en) begin
    for (int k = 1; k < 9; k++) ftx[k] <= ftx[k-1];
    for (int k = 1; k < 5; k++) fty[k] <= fty[k-1];
  end

  // stages 2-5: sixteen hashes
  logic signed [31:0] cv [4][4];
  for (genvar j = 0; j < 4; j++) begin : g_col
    for (genvar i = 0; i < 4; i++) begin : g_row
      bvns_hash u_hash (.clk, .en,
        .key({ys[i], xs[j]} ^ noise_seed), .value(cv[j][i]));
    end
  end

  // stages 6-9: interpolation along y
  logic signed [35:0] col [4];
  for (genvar j = 0; j < 4; j++) begin : g_cy
    bvns_catmull #(.W(32)) u_cy (.clk, .en, .p0(cv[j][0]), .p1(cv[j][1]),
      .p2(cv[j][2]), .p3(cv[j][3]), .t(fty[4]), .r(col[j]));
  end

  // stages 10-13: interpolation along x
  logic signed [39:0] v;
  bvns_catmull #(.W(36)) u_cx (.clk, .en, .p0(col[0]), .p1(col[1]),
    .p2(col[2]), .p3(col[3]), .t(ftx[8]), .r(v));

  // stages 14-16: amplitude scaling and saturation
  logic signed [55:0] mh;
  logic signed [56:0] ml;
  logic signed [63:0] q;
  logic signed [63:0] h;
  logic signed [39:0] hs;
  logic sat;
  always_ff @(posedge clk) if (en) begin
    mh <= v * $signed({1'b0, amplitude[30:16]});
    ml <= v * $signed({1'b0, amplitude[15:0]});
  end
  always_ff @(posedge clk) if (en) q <= 64'(mh) + 64'(ml >>> 16);
  assign h = q >>> (31 - FRAC_BITS);
  always_ff @(posedge clk) if (en) begin
    if (h > 64'sd549755813887) begin hs <= 40'sh7fffffffff; sat <= 1'b1; end
    else if (h < -64'sd549755813888) begin hs <= 40'sh8000000000; sat <= 1'b1; end
    else begin hs <= h[39:0]; sat <= 1'b0; end
  end
  assign m_axis_tdata = {7'd0, sat, hs};

  // output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[40] |->
      (m_axis_tdata[39:0] == 40'h7fffffffff || m_axis_tdata[39:0] == 40'h8000000000))
    else $error("saturated flag without clamp value");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved under stall");
endmodule
`default_nettype wire
